// ===== sv/hmt_pkg.sv =====
// shared types, constants and helpers for the heightmap triangulator
package hmt_pkg;

  localparam int unsigned LineMaxDef = 4096;

  // facet kinds
  localparam logic [1:0] KindSurface = 2'd0;
  localparam logic [1:0] KindWall    = 2'd1;
  localparam logic [1:0] KindBottom  = 2'd2;

  // register indexes
  localparam logic [2:0] RegColumns     = 3'd0;
  localparam logic [2:0] RegRows        = 3'd1;
  localparam logic [2:0] RegColumnPitch = 3'd2;
  localparam logic [2:0] RegRowPitch    = 3'd3;
  localparam logic [2:0] RegHeightGain  = 3'd4;
  localparam logic [2:0] RegBaseHeight  = 3'd5;
  localparam logic [2:0] RegFloodDepth  = 3'd6;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vert_t;

  typedef struct packed {
    logic [1:0] kind;
    vert_t      v0;
    vert_t      v1;
    vert_t      v2;
    logic       last;
  } facet_t;

  // sample context handed from the front stage to the facet sequencer
  typedef struct packed {
    logic signed [31:0] h;
    logic signed [31:0] above;
    logic signed [31:0] left;
    logic signed [31:0] upleft;
    logic signed [31:0] xc;
    logic signed [31:0] xl;
    logic signed [31:0] yr;
    logic signed [31:0] yd;
    logic               row0;
    logic               col0;
    logic               last_col;
    logic               last_row;
  } ctx_t;

  // saturate a 64-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // clamp an unsigned product to the positive 32-bit range
  function automatic logic signed [31:0] posclamp(input logic [47:0] p);
    logic signed [31:0] r;
    if (p > 48'h7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else r = $signed({1'b0, p[30:0]});
    return r;
  endfunction

endpackage

// ===== sv/heightmap_mesh_triangulator.sv =====
// top level of the heightmap triangulator
// Takes one elevation word per handshake in raster order and returns up to six
// facet words per sample. A two-stage front end (product and line store read,
// then rounding into a context register) feeds a facet sequencer that loads one
// facet per cycle into the output register while that register is empty or
// out_ready is high; a sample with no facets yields no facet words.
module heightmap_mesh_triangulator #(
  parameter int unsigned LINE_MAX = hmt_pkg::LineMaxDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_elevation,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_facet_kind,
  output logic signed [31:0] out_v0_x,
  output logic signed [31:0] out_v0_y,
  output logic signed [31:0] out_v0_z,
  output logic signed [31:0] out_v1_x,
  output logic signed [31:0] out_v1_y,
  output logic signed [31:0] out_v1_z,
  output logic signed [31:0] out_v2_x,
  output logic signed [31:0] out_v2_y,
  output logic signed [31:0] out_v2_z,
  output logic               out_last_of_sample,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic [12:0]        columns;
  logic [15:0]        rows;
  logic [30:0]        column_pitch, row_pitch, flood_depth;
  logic [31:0]        height_gain;
  logic signed [31:0] base_height;
  logic               ctx_valid, ctx_ready;
  hmt_pkg::ctx_t      ctx;
  hmt_pkg::facet_t    facet;

  hmt_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .columns, .rows, .column_pitch, .row_pitch,
    .height_gain, .base_height, .flood_depth
  );

  hmt_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_elevation, .columns, .rows,
    .column_pitch, .row_pitch, .height_gain, .base_height, .flood_depth,
    .ctx_valid, .ctx_ready, .ctx
  );

  hmt_seq u_seq (
    .clk, .rst_n, .ctx_valid, .ctx_ready, .ctx, .out_valid, .out_ready, .facet
  );

  assign out_facet_kind     = facet.kind;
  assign out_v0_x           = facet.v0.x;
  assign out_v0_y           = facet.v0.y;
  assign out_v0_z           = facet.v0.z;
  assign out_v1_x           = facet.v1.x;
  assign out_v1_y           = facet.v1.y;
  assign out_v1_z           = facet.v1.z;
  assign out_v2_x           = facet.v2.x;
  assign out_v2_y           = facet.v2.y;
  assign out_v2_z           = facet.v2.z;
  assign out_last_of_sample = facet.last;

endmodule

// ===== sv/hmt_cfg.sv =====
// configuration register bank on the APB-style port
module hmt_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output logic [12:0]         columns,
  output logic [15:0]         rows,
  output logic [30:0]         column_pitch,
  output logic [30:0]         row_pitch,
  output logic [31:0]         height_gain,
  output logic signed [31:0]  base_height,
  output logic [30:0]         flood_depth
);

  logic [12:0] columns_r;
  logic [15:0] rows_r;
  logic [30:0] column_pitch_r, row_pitch_r, flood_depth_r;
  logic [31:0] height_gain_r, base_height_r;
  logic [2:0]  idx;
  logic        wr;

  assign idx = cfg_paddr[4:2];
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r      <= 13'd10;
      rows_r         <= 16'd10;
      column_pitch_r <= 31'd65536;
      row_pitch_r    <= 31'd65536;
      height_gain_r  <= 32'd268435;
      base_height_r  <= 32'd196608;
      flood_depth_r  <= 31'd65536;
    end else if (wr) begin
      case (idx)
        hmt_pkg::RegColumns:     columns_r      <= cfg_pwdata[12:0];
        hmt_pkg::RegRows:        rows_r         <= cfg_pwdata[15:0];
        hmt_pkg::RegColumnPitch: column_pitch_r <= cfg_pwdata[30:0];
        hmt_pkg::RegRowPitch:    row_pitch_r    <= cfg_pwdata[30:0];
        hmt_pkg::RegHeightGain:  height_gain_r  <= cfg_pwdata;
        hmt_pkg::RegBaseHeight:  base_height_r  <= cfg_pwdata;
        hmt_pkg::RegFloodDepth:  flood_depth_r  <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      hmt_pkg::RegColumns:     cfg_prdata = {19'd0, columns_r};
      hmt_pkg::RegRows:        cfg_prdata = {16'd0, rows_r};
      hmt_pkg::RegColumnPitch: cfg_prdata = {1'b0, column_pitch_r};
      hmt_pkg::RegRowPitch:    cfg_prdata = {1'b0, row_pitch_r};
      hmt_pkg::RegHeightGain:  cfg_prdata = height_gain_r;
      hmt_pkg::RegBaseHeight:  cfg_prdata = base_height_r;
      hmt_pkg::RegFloodDepth:  cfg_prdata = {1'b0, flood_depth_r};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  assign columns      = columns_r;
  assign rows         = rows_r;
  assign column_pitch = column_pitch_r;
  assign row_pitch    = row_pitch_r;
  assign height_gain  = height_gain_r;
  assign base_height  = $signed(base_height_r);
  assign flood_depth  = flood_depth_r;

endmodule

// ===== sv/hmt_front.sv =====
// front end: height product, line store, grid position and coordinates
module hmt_front #(
  parameter int unsigned LINE_MAX = hmt_pkg::LineMaxDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [23:0]  in_elevation,
  input  logic [12:0]         columns,
  input  logic [15:0]         rows,
  input  logic [30:0]         column_pitch,
  input  logic [30:0]         row_pitch,
  input  logic [31:0]         height_gain,
  input  logic signed [31:0]  base_height,
  input  logic [30:0]         flood_depth,
  output logic                ctx_valid,
  input  logic                ctx_ready,
  output hmt_pkg::ctx_t       ctx
);

  localparam int unsigned IdxW = $clog2(LINE_MAX);
  localparam int unsigned PosW = IdxW + 1;

  // stage 1: product, position and line store read; stage 2: height and context
  logic               s1_valid_r, s2_valid_r;
  logic               s1_zero_r;
  logic signed [56:0] s1_prod_r;
  logic [PosW-1:0]    s1_col_r;
  logic [15:0]        s1_row_r;
  logic               s1_lc_r, s1_lr_r;
  logic [47:0]        s1_xc_r, s1_xl_r, s1_yr_r, s1_yd_r;

  logic [PosW-1:0]    col_r;
  logic [15:0]        row_r;
  logic signed [31:0] left_r, upleft_r;

  logic [31:0]        mem [LINE_MAX];
  logic [31:0]        rd_r;
  hmt_pkg::ctx_t      s2_r;

  logic [PosW:0]      cols_c;
  logic [15:0]        rows_c;
  logic               lc, lr, adv1, adv2, s2_free;
  logic signed [31:0] h_nxt;
  logic signed [56:0] t;
  logic signed [56:0] q;

  // clamp grid size
  always_comb begin
    if (columns < 13'd2) cols_c = (PosW+1)'(2);
    else if (32'(columns) > LINE_MAX) cols_c = (PosW+1)'(LINE_MAX);
    else cols_c = (PosW+1)'(columns);
    rows_c = (rows < 16'd2) ? 16'd2 : rows;
  end

  assign lc = ({1'b0, col_r} >= cols_c - (PosW+1)'(1));
  assign lr = (row_r >= rows_c - 16'd1);

  assign s2_free = !s2_valid_r || ctx_ready;
  assign adv2 = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;
  assign adv1 = in_valid && in_ready;

  // stage 1 valid and grid position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      col_r <= '0;
      row_r <= '0;
    end else begin
      if (adv1) begin
        s1_valid_r <= 1'b1;
        if (lc) begin
          col_r <= '0;
          row_r <= lr ? 16'd0 : row_r + 16'd1;
        end else begin
          col_r <= col_r + PosW'(1);
        end
      end else if (adv2) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // stage 1 data
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_zero_r <= (in_elevation == 24'sd0);
      s1_prod_r <= 57'(in_elevation) * 57'($signed({1'b0, height_gain}));
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_lc_r   <= lc;
      s1_lr_r   <= lr;
      s1_xc_r   <= {{(48-PosW){1'b0}}, col_r} * {17'd0, column_pitch};
      s1_xl_r   <= {{(48-PosW){1'b0}}, col_r - PosW'(1)} * {17'd0, column_pitch};
      s1_yr_r   <= {32'd0, row_r} * {17'd0, row_pitch};
      s1_yd_r   <= {32'd0, row_r - 16'd1} * {17'd0, row_pitch};
    end
  end

  // line store: read on accept, written as the sample leaves stage 1
  always_ff @(posedge clk) begin
    if (adv2) begin
      mem[s1_col_r[IdxW-1:0]] <= h_nxt;
    end
    if (adv1) begin
      rd_r <= mem[col_r[IdxW-1:0]];
    end
  end

  // product rounded half up plus base, or base minus flood if zero; saturated
  assign t = s1_prod_r + 57'sd524288;
  assign q = t >>> 20;
  always_comb begin
    if (s1_zero_r) h_nxt = hmt_pkg::sat32(64'(base_height) - 64'($signed({1'b0, flood_depth})));
    else h_nxt = hmt_pkg::sat32(64'(q) + 64'(base_height));
  end

  // neighbour heights of the previous sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      upleft_r <= '0;
    end else if (adv2) begin
      left_r <= h_nxt;
      upleft_r <= $signed(rd_r);
    end
  end

  // stage 2 context register
  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_r.h <= h_nxt;
      s2_r.above <= $signed(rd_r);
      s2_r.left <= left_r;
      s2_r.upleft <= upleft_r;
      s2_r.xc <= hmt_pkg::posclamp(s1_xc_r);
      s2_r.xl <= (s1_col_r == '0) ? 32'sd0 : hmt_pkg::posclamp(s1_xl_r);
      s2_r.yr <= hmt_pkg::posclamp(s1_yr_r);
      s2_r.yd <= (s1_row_r == 16'd0) ? 32'sd0 : hmt_pkg::posclamp(s1_yd_r);
      s2_r.row0 <= (s1_row_r == 16'd0);
      s2_r.col0 <= (s1_col_r == '0);
      s2_r.last_col <= s1_lc_r;
      s2_r.last_row <= s1_lr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else if (adv2) s2_valid_r <= 1'b1;
    else if (ctx_ready) s2_valid_r <= 1'b0;
  end

  assign ctx_valid = s2_valid_r;
  assign ctx = s2_r;

endmodule

// ===== sv/hmt_seq.sv =====
// facet sequencer: walks the facets of one sample into an output register
module hmt_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ctx_valid,
  output logic           ctx_ready,
  input  hmt_pkg::ctx_t  ctx,
  output logic           out_valid,
  input  logic           out_ready,
  output hmt_pkg::facet_t facet
);

  // facet slots: two surface, two bottom, east wall, north wall, or one lone wall
  logic [2:0]        slot_r, slot_nxt;
  logic [5:0]        mask;
  logic              busy;
  hmt_pkg::facet_t   f;
  hmt_pkg::facet_t   out_r;
  logic              out_valid_r;
  logic              take, load;
  logic [2:0]        first, nxt_slot;
  logic              more;
  hmt_pkg::vert_t    a, b, c, d, ca, cb, cc, cd, zv;
  logic signed [32:0] d1, d2;
  logic [31:0]       ad1, ad2;
  logic              split;
  logic [5:0]        rest;

  // which slots this sample uses
  always_comb begin
    mask = 6'd0;
    if (ctx.row0) mask[4] = !ctx.col0;
    else begin
      mask[3:0] = ctx.col0 ? 4'b0000 : 4'b1111;
      mask[5] = ctx.col0;
      mask[4] = ctx.last_col;
      if (ctx.last_row && !ctx.col0) mask[5] = 1'b1;
    end
  end

  assign zv = '0;
  assign a = '{ctx.xc, ctx.yr, ctx.h};
  assign b = '{ctx.xc, ctx.yd, ctx.above};
  assign c = '{ctx.xl, ctx.yd, ctx.upleft};
  assign d = '{ctx.xl, ctx.yr, ctx.left};
  assign ca = '{ctx.xc, ctx.yr, 32'sd0};
  assign cb = '{ctx.xc, ctx.yd, 32'sd0};
  assign cc = '{ctx.xl, ctx.yd, 32'sd0};
  assign cd = '{ctx.xl, ctx.yr, 32'sd0};
  assign d1 = 33'(ctx.left) - 33'(ctx.above);
  assign d2 = 33'(ctx.h) - 33'(ctx.upleft);
  assign ad1 = d1[32] ? 32'(-d1) : d1[31:0];
  assign ad2 = d2[32] ? 32'(-d2) : d2[31:0];
  assign split = ad1 < ad2;

  // first used slot at or after current position
  always_comb begin
    first = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (mask[i] && 3'(i) >= slot_r) first = 3'(i);
    end
    rest = 6'd0;
    for (int i = 0; i < 6; i++) rest[i] = mask[i] && 3'(i) > first;
    more = |rest;
  end

  // facet for the selected slot
  always_comb begin
    f = '0;
    case (first)
      3'd0: begin
        f.kind = hmt_pkg::KindSurface;
        if (split) begin f.v0 = a; f.v1 = d; f.v2 = b; end
        else begin f.v0 = a; f.v1 = d; f.v2 = c; end
      end
      3'd1: begin
        f.kind = hmt_pkg::KindSurface;
        if (split) begin f.v0 = c; f.v1 = b; f.v2 = d; end
        else begin f.v0 = a; f.v1 = c; f.v2 = b; end
      end
      3'd2: begin
        f.kind = hmt_pkg::KindBottom; f.v0 = cc; f.v1 = ca; f.v2 = cb;
      end
      3'd3: begin
        f.kind = hmt_pkg::KindBottom; f.v0 = cc; f.v1 = cd; f.v2 = ca;
      end
      3'd4: begin
        f.kind = hmt_pkg::KindWall;
        if (ctx.row0) begin f.v0 = '{ctx.xl, 32'sd0, ctx.left}; f.v1 = '{ctx.xc, 32'sd0, ctx.h}; end
        else begin f.v0 = b; f.v1 = a; end
      end
      3'd5: begin
        f.kind = hmt_pkg::KindWall;
        if (ctx.col0) begin f.v0 = a; f.v1 = b; end
        else begin f.v0 = d; f.v1 = a; end
      end
      default: f = '0;
    endcase
    f.v2 = (f.kind == hmt_pkg::KindWall) ? zv : f.v2;
    f.last = !more;
  end

  assign busy = ctx_valid && (mask != 6'd0);
  assign take = !out_valid_r || out_ready;
  assign load = busy && take;
  // finish the sample when last facet loads, or at once when it has none
  assign ctx_ready = ctx_valid && ((mask == 6'd0) || (load && !more));
  assign nxt_slot = first + 3'd1;

  always_comb begin
    slot_nxt = slot_r;
    if (ctx_ready) slot_nxt = 3'd0;
    else if (load) slot_nxt = nxt_slot;
  end

  // slot counter and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= f;
  end

  assign out_valid = out_valid_r;
  assign facet = out_r;

endmodule
